// File: rtl/sdm_pkg.sv
// Shared constants, types and a helper function for the stereo downmix matrix.
package sdm_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int COEF_WIDTH   = 16;

    localparam int NUM_LANES  = 8;
    localparam int SAMPLE_W   = 32;
    localparam int OUT_W      = 32;
    localparam int CNT_W      = 4;
    localparam int CFG_W      = 64;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_COEF   = 4;
    localparam int SLICE_W    = 16;
    localparam int COEF_FIELD = (COEF_WIDTH > SLICE_W) ? SLICE_W : COEF_WIDTH;
    localparam int COEF_FRAC  = COEF_WIDTH - 2;
    localparam int PROD_W     = SAMPLE_W + COEF_WIDTH;
    localparam int SUM_W      = PROD_W + 3;
    localparam int RND_W      = SUM_W + 1;

    localparam logic [OUT_W-1:0] LIM_NARROW = 32'd32767;
    localparam logic [OUT_W-1:0] LIM_WIDE   = 32'd2147483647;

    localparam logic [CFG_IDX_W-1:0] CFG_COEF_01 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_23 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_45 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_67 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE    = 3'd5;

    localparam logic [CFG_W-1:0] RST_COEF_01 = 64'd2305843009213702144;
    localparam logic [CFG_W-1:0] RST_COEF_23 = 64'd816289888246175400;
    localparam logic [CFG_W-1:0] RST_COEF_45 = 64'd1152921504606851072;
    localparam logic [CFG_W-1:0] RST_COEF_67 = 64'd0;
    localparam logic [CNT_W-1:0] RST_ACTIVE  = 4'd6;

    typedef logic signed [COEF_WIDTH-1:0] t_coef;
    typedef logic signed [PROD_W-1:0]     t_prod;

    typedef struct packed {
        logic vld;
        logic blk_end;
    } t_ctl;

    function automatic t_coef coef_ext(input logic [COEF_FIELD-1:0] slice);
        return COEF_WIDTH'($signed(slice));
    endfunction

endpackage

// File: rtl/sdm_lane.sv
// One channel lane: selects the sample width and forms both registered products.
module sdm_lane
    import sdm_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_en,
    input  logic                i_active,
    input  logic                i_wide,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  t_coef               i_coef_l,
    input  t_coef               i_coef_r,
    output t_prod               o_prod_l,
    output t_prod               o_prod_r
);

    logic signed [SAMPLE_W-1:0] smp;
    t_prod                      n_prod_l;
    t_prod                      n_prod_r;
    t_prod                      r_prod_l;
    t_prod                      r_prod_r;

    always_comb begin
        smp = i_wide ? $signed(i_sample) : SAMPLE_W'($signed(i_sample[15:0]));
        n_prod_l = PROD_W'(smp) * PROD_W'(i_coef_l);
        n_prod_r = PROD_W'(smp) * PROD_W'(i_coef_r);
        if (!i_active) begin
            n_prod_l = '0;
            n_prod_r = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_l <= n_prod_l;
            r_prod_r <= n_prod_r;
        end
    end

    assign o_prod_l = r_prod_l;
    assign o_prod_r = r_prod_r;

endmodule

// File: rtl/sdm_merge.sv
// Registered adder tree over the lane products, then rounding and clamping.
module sdm_merge
    import sdm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wide,
    input  t_ctl             i_ctl,
    output logic             o_rdy,
    input  t_prod            i_prod_l [NUM_LANES],
    input  t_prod            i_prod_r [NUM_LANES],
    output logic             o_valid,
    input  logic             i_ready,
    output logic [OUT_W-1:0] o_left_mix,
    output logic [OUT_W-1:0] o_right_mix,
    output logic             o_block_end_out
);

    localparam int L2_W = PROD_W + 1;
    localparam int L3_W = PROD_W + 2;

    function automatic logic [OUT_W-1:0] finish(input logic signed [RND_W-1:0] v,
                                                input logic wide);
        logic signed [RND_W-1:0] q;
        logic signed [RND_W-1:0] lim;
        q   = v >>> COEF_FRAC;
        lim = wide ? $signed(RND_W'(LIM_WIDE)) : $signed(RND_W'(LIM_NARROW));
        if (v[RND_W-1] && (|v[COEF_FRAC-1:0])) begin
            q = q + RND_W'(1);
        end
        if (q > lim) begin
            q = lim;
        end else if (q < -lim) begin
            q = -lim;
        end
        return q[OUT_W-1:0];
    endfunction

    logic                    r_v2, r_v3, r_v4, r_v5;
    logic                    r_e2, r_e3, r_e4, r_e5;
    logic                    en2, en3, en4, en5;
    logic signed [L2_W-1:0]  r_s2_l [4];
    logic signed [L2_W-1:0]  r_s2_r [4];
    logic signed [L3_W-1:0]  r_s3_l [2];
    logic signed [L3_W-1:0]  r_s3_r [2];
    logic signed [RND_W-1:0] r_s4_l;
    logic signed [RND_W-1:0] r_s4_r;
    logic [OUT_W-1:0]        r_out_l;
    logic [OUT_W-1:0]        r_out_r;
    logic signed [RND_W-1:0] half;

    assign half = RND_W'(1) <<< (COEF_FRAC - 1);

    assign en5   = !r_v5 || i_ready;
    assign en4   = !r_v4 || en5;
    assign en3   = !r_v3 || en4;
    assign en2   = !r_v2 || en3;
    assign o_rdy = en2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en2) begin
                r_v2 <= i_ctl.vld;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (en4) begin
                r_v4 <= r_v3;
            end
            if (en5) begin
                r_v5 <= r_v4;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_e2 <= i_ctl.blk_end;
            for (int i = 0; i < 4; i++) begin
                r_s2_l[i] <= L2_W'(i_prod_l[2*i]) + L2_W'(i_prod_l[2*i+1]);
                r_s2_r[i] <= L2_W'(i_prod_r[2*i]) + L2_W'(i_prod_r[2*i+1]);
            end
        end
        if (en3) begin
            r_e3 <= r_e2;
            for (int i = 0; i < 2; i++) begin
                r_s3_l[i] <= L3_W'(r_s2_l[2*i]) + L3_W'(r_s2_l[2*i+1]);
                r_s3_r[i] <= L3_W'(r_s2_r[2*i]) + L3_W'(r_s2_r[2*i+1]);
            end
        end
        if (en4) begin
            r_e4   <= r_e3;
            r_s4_l <= RND_W'(r_s3_l[0]) + RND_W'(r_s3_l[1]) + half;
            r_s4_r <= RND_W'(r_s3_r[0]) + RND_W'(r_s3_r[1]) + half;
        end
        if (en5) begin
            r_e5    <= r_e4;
            r_out_l <= finish(r_s4_l, i_wide);
            r_out_r <= finish(r_s4_r, i_wide);
        end
    end

    assign o_valid         = r_v5;
    assign o_left_mix      = r_out_l;
    assign o_right_mix     = r_out_r;
    assign o_block_end_out = r_e5;

endmodule

// File: rtl/stereo_downmix_matrix.sv
// Top level of the eight-channel to stereo downmix matrix with its register file.
// The block takes one frame per clock while o_ready is high and returns its stereo
// pair through the eight multiplier lane registers, the registered adder tree
// and rounding and clamping into the output register.
// Every stage holds its own valid bit, so a stalled output fills the empty
// stages behind it before the input word is held off. Configuration writes take
// effect at once and should be made only while no word is in flight.
module stereo_downmix_matrix
    import sdm_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [SAMPLE_W-1:0]  i_sample_0,
    input  logic [SAMPLE_W-1:0]  i_sample_1,
    input  logic [SAMPLE_W-1:0]  i_sample_2,
    input  logic [SAMPLE_W-1:0]  i_sample_3,
    input  logic [SAMPLE_W-1:0]  i_sample_4,
    input  logic [SAMPLE_W-1:0]  i_sample_5,
    input  logic [SAMPLE_W-1:0]  i_sample_6,
    input  logic [SAMPLE_W-1:0]  i_sample_7,
    input  logic                 i_block_end,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [OUT_W-1:0]     o_left_mix,
    output logic [OUT_W-1:0]     o_right_mix,
    output logic                 o_block_end_out
);

    logic [CFG_W-1:0]    r_coef [NUM_COEF];
    logic [CNT_W-1:0]    r_active;
    logic                r_wide;
    logic                r_s1_vld;
    logic                r_s1_end;
    logic                en1;
    logic                merge_rdy;
    logic [CNT_W-1:0]    n_used;
    logic [NUM_LANES-1:0] lane_on;
    logic [SAMPLE_W-1:0] samples [NUM_LANES];
    t_coef               coef_l [NUM_LANES];
    t_coef               coef_r [NUM_LANES];
    t_prod               prod_l [NUM_LANES];
    t_prod               prod_r [NUM_LANES];
    t_ctl                s1_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= RST_COEF_01;
            r_coef[1] <= RST_COEF_23;
            r_coef[2] <= RST_COEF_45;
            r_coef[3] <= RST_COEF_67;
            r_active  <= RST_ACTIVE;
            r_wide    <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_COEF_01: r_coef[0] <= i_cfg_data;
                CFG_COEF_23: r_coef[1] <= i_cfg_data;
                CFG_COEF_45: r_coef[2] <= i_cfg_data;
                CFG_COEF_67: r_coef[3] <= i_cfg_data;
                CFG_ACTIVE:  r_active  <= i_cfg_data[CNT_W-1:0];
                CFG_WIDE:    r_wide    <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    assign n_used = (r_active > CNT_W'(MAX_CHANNELS)) ? CNT_W'(MAX_CHANNELS) : r_active;

    assign samples[0] = i_sample_0;
    assign samples[1] = i_sample_1;
    assign samples[2] = i_sample_2;
    assign samples[3] = i_sample_3;
    assign samples[4] = i_sample_4;
    assign samples[5] = i_sample_5;
    assign samples[6] = i_sample_6;
    assign samples[7] = i_sample_7;

    assign en1     = !r_s1_vld || merge_rdy;
    assign o_ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (en1) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_end <= i_block_end;
        end
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        assign lane_on[g] = CNT_W'(g) < n_used;
        assign coef_l[g]  = coef_ext(r_coef[g/2][(g%2)*2*SLICE_W +: COEF_FIELD]);
        assign coef_r[g]  = coef_ext(r_coef[g/2][(g%2)*2*SLICE_W + SLICE_W +: COEF_FIELD]);

        sdm_lane u_lane (
            .i_clk    (i_clk),
            .i_en     (en1),
            .i_active (lane_on[g]),
            .i_wide   (r_wide),
            .i_sample (samples[g]),
            .i_coef_l (coef_l[g]),
            .i_coef_r (coef_r[g]),
            .o_prod_l (prod_l[g]),
            .o_prod_r (prod_r[g])
        );
    end

    assign s1_ctl.vld     = r_s1_vld;
    assign s1_ctl.blk_end = r_s1_end;

    sdm_merge u_merge (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_wide          (r_wide),
        .i_ctl           (s1_ctl),
        .o_rdy           (merge_rdy),
        .i_prod_l        (prod_l),
        .i_prod_r        (prod_r),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_left_mix      (o_left_mix),
        .o_right_mix     (o_right_mix),
        .o_block_end_out (o_block_end_out)
    );

endmodule

// File: rtl/sdm_check.sv
// Port-level checker for the stereo downmix matrix and its bind statement.
module sdm_check
    import sdm_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             o_ready,
    input  logic             o_valid,
    input  logic             i_ready,
    input  logic [OUT_W-1:0] o_left_mix,
    input  logic [OUT_W-1:0] o_right_mix,
    input  logic             o_block_end_out
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output word valid right after reset.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_left_mix)
            && $stable(o_right_mix) && $stable(o_block_end_out))
        else $error("Stalled output word changed.");

    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("Input held off while the output is free.");

    a_symmetric_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_left_mix != 32'h8000_0000 && o_right_mix != 32'h8000_0000)
        else $error("Output word outside the symmetric limit.");

endmodule

bind stereo_downmix_matrix sdm_check u_sdm_check (.*);

// File: dv/stereo_downmix_matrix_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the eight-channel to stereo downmix matrix.
module stereo_downmix_matrix_tb;
    import sdm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;

    typedef struct packed {
        logic [NUM_LANES-1:0][SAMPLE_W-1:0] smp;
        logic                               blk_end;
    } t_frame;

    typedef struct packed {
        logic [OUT_W-1:0] left;
        logic [OUT_W-1:0] right;
        logic             blk_end;
    } t_pair;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    logic [SAMPLE_W-1:0]  i_sample_0  = '0;
    logic [SAMPLE_W-1:0]  i_sample_1  = '0;
    logic [SAMPLE_W-1:0]  i_sample_2  = '0;
    logic [SAMPLE_W-1:0]  i_sample_3  = '0;
    logic [SAMPLE_W-1:0]  i_sample_4  = '0;
    logic [SAMPLE_W-1:0]  i_sample_5  = '0;
    logic [SAMPLE_W-1:0]  i_sample_6  = '0;
    logic [SAMPLE_W-1:0]  i_sample_7  = '0;
    logic                 i_block_end = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    logic [OUT_W-1:0]     o_left_mix;
    logic [OUT_W-1:0]     o_right_mix;
    logic                 o_block_end_out;

    logic [CFG_W-1:0] coef_mdl [NUM_COEF];
    logic [CNT_W-1:0] active_mdl;
    logic             wide_mdl;

    t_pair pair_q [$];

    bit tx_idle_en = 1'b0;
    bit rx_idle_en = 1'b0;
    bit hold_req   = 1'b0;

    int frames_sent   = 0;
    int words_checked = 0;
    int reg_writes    = 0;
    int n_errors      = 0;

    stereo_downmix_matrix DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_sample_0      (i_sample_0),
        .i_sample_1      (i_sample_1),
        .i_sample_2      (i_sample_2),
        .i_sample_3      (i_sample_3),
        .i_sample_4      (i_sample_4),
        .i_sample_5      (i_sample_5),
        .i_sample_6      (i_sample_6),
        .i_sample_7      (i_sample_7),
        .i_block_end     (i_block_end),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_left_mix      (o_left_mix),
        .o_right_mix     (o_right_mix),
        .o_block_end_out (o_block_end_out)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_pair mix_frame(input t_frame f);
        t_pair                          p;
        longint                         acc [2];
        longint                         smp_v;
        longint                         lim;
        longint                         v;
        logic signed [COEF_FIELD-1:0]   cf;
        int                             n;
        n = (active_mdl > MAX_CHANNELS) ? MAX_CHANNELS : int'(active_mdl);
        acc[0] = 0;
        acc[1] = 0;
        for (int ch = 0; ch < n; ch++) begin
            if (wide_mdl) begin
                smp_v = longint'($signed(f.smp[ch]));
            end else begin
                smp_v = longint'($signed(f.smp[ch][15:0]));
            end
            for (int side = 0; side < 2; side++) begin
                cf = coef_mdl[ch / 2][SLICE_W * (2 * (ch % 2) + side) +: COEF_FIELD];
                acc[side] += smp_v * longint'(cf);
            end
        end
        lim = wide_mdl ? longint'(LIM_WIDE) : longint'(LIM_NARROW);
        for (int side = 0; side < 2; side++) begin
            v = (acc[side] + (longint'(1) <<< (COEF_FRAC - 1))) / (longint'(1) <<< COEF_FRAC);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            if (side == 0) begin
                p.left = v[OUT_W-1:0];
            end else begin
                p.right = v[OUT_W-1:0];
            end
        end
        p.blk_end = f.blk_end;
        return p;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [15:0] h;
        h = 16'($urandom);
        case ($urandom_range(0, 11))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return {h, 16'h7FFF};
            3:       return {h, 16'h8000};
            4:       return '0;
            5, 6, 7: return {{16{h[15]}}, h};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SLICE_W-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h2000;
            1:       return 16'h16A8;
            2:       return 16'h0B54;
            3:       return 16'h1000;
            4:       return 16'hE000;
            5:       return 16'h7FFF;
            6:       return 16'h8000;
            7:       return ($urandom_range(0, 1) == 1) ? 16'h0001 : 16'hFFFF;
            default: return SLICE_W'($urandom);
        endcase
    endfunction

    function automatic t_frame uniform_frame(input logic [SAMPLE_W-1:0] v, input logic blk);
        t_frame f;
        for (int ch = 0; ch < NUM_LANES; ch++) f.smp[ch] = v;
        f.blk_end = blk;
        return f;
    endfunction

    function automatic t_frame random_frame();
        t_frame f;
        for (int ch = 0; ch < NUM_LANES; ch++) f.smp[ch] = pick_sample();
        f.blk_end = 1'($urandom_range(0, 1));
        return f;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(posedge i_clk);
        reg_writes++;
        case (idx)
            CFG_COEF_01: coef_mdl[0] = data;
            CFG_COEF_23: coef_mdl[1] = data;
            CFG_COEF_45: coef_mdl[2] = data;
            CFG_COEF_67: coef_mdl[3] = data;
            CFG_ACTIVE:  active_mdl = data[CNT_W-1:0];
            CFG_WIDE:    wide_mdl = data[0];
            default: ;
        endcase
    endtask

    task automatic set_all_coefs(input logic [SLICE_W-1:0] cl, input logic [SLICE_W-1:0] cr);
        write_reg(CFG_COEF_01, {cr, cl, cr, cl});
        write_reg(CFG_COEF_23, {cr, cl, cr, cl});
        write_reg(CFG_COEF_45, {cr, cl, cr, cl});
        write_reg(CFG_COEF_67, {cr, cl, cr, cl});
    endtask

    task automatic send_frame(input t_frame f);
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_0  <= f.smp[0];
        i_sample_1  <= f.smp[1];
        i_sample_2  <= f.smp[2];
        i_sample_3  <= f.smp[3];
        i_sample_4  <= f.smp[4];
        i_sample_5  <= f.smp[5];
        i_sample_6  <= f.smp[6];
        i_sample_7  <= f.smp[7];
        i_block_end <= f.blk_end;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pair_q.push_back(mix_frame(f));
        frames_sent++;
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pair_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic check_pair();
        t_pair want;
        words_checked++;
        if (pair_q.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("[%0t] unexpected word: left=%0d right=%0d end=%0b", $time,
                         $signed(o_left_mix), $signed(o_right_mix), o_block_end_out);
        end else begin
            want = pair_q.pop_front();
            if (o_left_mix !== want.left || o_right_mix !== want.right ||
                o_block_end_out !== want.blk_end) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display({"[%0t] mismatch: expected left=%0d right=%0d end=%0b, ",
                              "got left=%0d right=%0d end=%0b"},
                             $time, $signed(want.left), $signed(want.right), want.blk_end,
                             $signed(o_left_mix), $signed(o_right_mix), o_block_end_out);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) check_pair();
    end

    initial begin : rx_side
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                i_ready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    task automatic test_reset_defaults();
        t_frame f;
        send_frame(uniform_frame(32'h0000_0000, 1'b0));
        send_frame(uniform_frame(32'h0000_7FFF, 1'b1));
        send_frame(uniform_frame(32'hFFFF_8000, 1'b0));
        f = uniform_frame(32'hA5A5_1234, 1'b1);
        f.smp[6] = 32'h5A5A_EDCB;
        f.smp[7] = 32'h7FFF_8000;
        send_frame(f);
        wait_idle();
    endtask

    task automatic test_narrow_limits();
        set_all_coefs(16'h7FFF, 16'h8000);
        write_reg(CFG_ACTIVE, 64'd8);
        send_frame(uniform_frame(32'h0000_7FFF, 1'b1));
        send_frame(uniform_frame(32'h5A5A_8000, 1'b0));
        wait_idle();
    endtask

    task automatic test_wide_limits();
        t_frame f;
        write_reg(CFG_WIDE, 64'd1);
        send_frame(uniform_frame(32'h7FFF_FFFF, 1'b1));
        send_frame(uniform_frame(32'h8000_0000, 1'b0));
        wait_idle();
        write_reg(CFG_COEF_01, {16'hC000, 16'h0001, 16'h0001, 16'h4000});
        f = uniform_frame(32'h0000_0000, 1'b1);
        f.smp[0] = 32'h1234_5678;
        f.smp[1] = 32'hEDCB_A987;
        send_frame(f);
        wait_idle();
    endtask

    task automatic test_rounding();
        logic [SAMPLE_W-1:0] probes [5];
        t_frame              f;
        probes = '{32'h0000_2000, 32'hFFFF_E000, 32'h0000_1FFF, 32'hFFFF_DFFF, 32'hFFFF_9FFF};
        write_reg(CFG_WIDE, 64'd0);
        write_reg(CFG_ACTIVE, 64'd1);
        write_reg(CFG_COEF_01, {16'h3000, 16'h5000, 16'hFFFF, 16'h0001});
        for (int i = 0; i < 5; i++) begin
            f = random_frame();
            f.smp[0] = probes[i];
            send_frame(f);
        end
        wait_idle();
    endtask

    task automatic test_channel_count();
        logic [CNT_W-1:0] counts [5];
        logic [CFG_W-1:0] d;
        counts = '{4'd0, 4'd1, 4'd8, 4'd9, 4'd15};
        set_all_coefs(16'h1000, 16'hF4AC);
        for (int i = 0; i < 5; i++) begin
            d = {$urandom, $urandom};
            d[CNT_W-1:0] = counts[i];
            write_reg(CFG_ACTIVE, d);
            send_frame(random_frame());
            wait_idle();
        end
        write_reg(CFG_SPARE_6, {$urandom, $urandom});
        write_reg(CFG_SPARE_7, {$urandom, $urandom});
        send_frame(random_frame());
        wait_idle();
    endtask

    task automatic test_backpressure();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        hold_req   = 1'b1;
        repeat (40) send_frame(random_frame());
        wait_idle();
    endtask

    task automatic run_phase(input int n_frames, input bit idle);
        logic [CFG_W-1:0] d;
        tx_idle_en = idle;
        rx_idle_en = idle;
        write_reg(CFG_COEF_01, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
        write_reg(CFG_COEF_23, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
        write_reg(CFG_COEF_45, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
        write_reg(CFG_COEF_67, {pick_coef(), pick_coef(), pick_coef(), pick_coef()});
        d = {$urandom, $urandom};
        d[CNT_W-1:0] = ($urandom_range(0, 5) == 0) ? CNT_W'($urandom_range(0, 15))
                                                    : CNT_W'($urandom_range(1, 8));
        write_reg(CFG_ACTIVE, d);
        write_reg(CFG_WIDE, {$urandom, $urandom});
        repeat (n_frames) send_frame(random_frame());
        wait_idle();
    endtask

    task automatic test_random_traffic();
        for (int ph = 0; ph < 7; ph++) run_phase(220, 1'b1);
        run_phase(160, 1'b0);
    endtask

    initial begin : main_seq
        coef_mdl[0] = RST_COEF_01;
        coef_mdl[1] = RST_COEF_23;
        coef_mdl[2] = RST_COEF_45;
        coef_mdl[3] = RST_COEF_67;
        active_mdl  = RST_ACTIVE;
        wide_mdl    = 1'b0;
        tx_idle_en  = 1'b1;
        rx_idle_en  = 1'b1;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_defaults();
        test_narrow_limits();
        test_wide_limits();
        test_rounding();
        test_channel_count();
        test_backpressure();
        test_random_traffic();
        n_errors += pair_q.size();
        $display("Summary: %0d frames sent, %0d stereo words checked, %0d register writes.",
                 frames_sent, words_checked, reg_writes);
        $display({"Covered both sample widths, channel counts 0 to 15, clamping, rounding ",
                  "and a %0d-cycle output stall; %0d mismatches."},
                 HOLD_CYCLES, n_errors);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: files.f
rtl/sdm_pkg.sv
rtl/sdm_lane.sv
rtl/sdm_merge.sv
rtl/stereo_downmix_matrix.sv
rtl/sdm_check.sv
dv/stereo_downmix_matrix_tb.sv
